// ===== hdl/cau_pkg.sv =====
// shared types, constants and saturation helper for the complex arithmetic unit
package cau_pkg;

  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned MaxExponentDef = 255;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_CONJ = 3'd4,
    KIND_SQM  = 3'd5,
    KIND_POW  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  // quotient part handed back by the divider
  typedef struct packed {
    logic signed [31:0] q;
    logic               sat;
  } div_res_t;

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t r;
    if (v > 65'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.hit = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = 32'sh80000000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/cau_mul.sv =====
// shared registered 32x32 signed multiplier with floor shift of the fraction
module cau_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  output logic signed [63:0] tr_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= x_i * y_i;
  end

  // arithmetic shift gives rounding toward minus infinity
  assign tr_o = p_q >>> FRAC_BITS;

endmodule

// ===== hdl/cau_div.sv =====
// restoring divider, one quotient bit a cycle, signed result saturated to 32 bits
module cau_div
  import cau_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic        [31:0] den_i,
  output logic               done_o,
  output div_res_t           res_o
);

  localparam int unsigned DW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);
  localparam logic [DW-1:0] LIM_POS = DW'(64'h7fffffff);
  localparam logic [DW-1:0] LIM_NEG = DW'(64'h80000000);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q;
  logic [31:0]   den_q;
  logic [DW-1:0] dd_q;
  logic          neg_q;
  div_res_t      res_q;

  logic [32:0]   rem_sh;
  logic          ge;
  logic [32:0]   rem_nx;
  logic [DW-1:0] q_fin;
  logic [DW-1:0] q_neg;
  logic [31:0]   mag;
  div_res_t      res_d;

  always_comb begin
    mag    = num_i[31] ? (~num_i + 32'd1) : num_i;
    rem_sh = {rem_q, dd_q[DW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    q_fin  = {dd_q[DW-2:0], ge};
    q_neg  = DW'(0) - q_fin;
    if (neg_q) begin
      if (q_fin > LIM_NEG) begin
        res_d.q   = 32'sh80000000;
        res_d.sat = 1'b1;
      end else begin
        res_d.q   = q_neg[31:0];
        res_d.sat = 1'b0;
      end
    end else if (q_fin > LIM_POS) begin
      res_d.q   = 32'sh7fffffff;
      res_d.sat = 1'b1;
    end else begin
      res_d.q   = q_fin[31:0];
      res_d.sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= den_i;
        dd_q   <= DW'(mag) << FRAC_BITS;
        neg_q  <= num_i[31];
      end else if (busy_q) begin
        rem_q  <= rem_nx[31:0];
        dd_q   <= q_fin;
        cnt_q  <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= res_d;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hdl/complex_arith_unit.sv =====
// top level of the Q16.16 complex arithmetic unit: sequencer around a shared multiplier
// add, sub, conj, unused codes and zero power give the result in the cycle after start
// mul and squared magnitude run one multiply pass, integer power one pass for each of its n multiplies
// div runs a pass for a times conj(b), one for |b|^2, then the bit-serial divider on re and im
// one transaction at a time: multi-cycle ops hold busy up to the result strobe, never stalled
// asynchronous active-low reset returns the sequencer to idle with no strobe pending
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FracBitsDef,
  parameter int unsigned MAX_EXPONENT = MaxExponentDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic        [2:0]  kind_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic        [7:0]  exponent_i,
  output logic               done_o,
  output logic signed [31:0] result_re_o,
  output logic signed [31:0] result_im_o,
  output logic        [1:0]  status_o
);

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DIV
  } state_e;

  // what the current complex multiply pass feeds
  typedef enum logic [2:0] {
    PH_MUL,
    PH_SQM,
    PH_POW,
    PH_DIVN,
    PH_DIVD
  } phase_e;

  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic        [15:0] MAX_E = 16'(MAX_EXPONENT);

  state_e             state_q;
  phase_e             phase_q;
  logic [2:0]         step_q;
  logic signed [31:0] xr_q, xi_q, yr_q, yi_q;
  logic signed [31:0] br_q, bi_q;
  logic signed [31:0] nr_q, ni_q;
  logic        [31:0] d_q;
  logic signed [64:0] acc_re_q, acc_im_q;
  logic        [7:0]  cnt_q;
  logic               sq_q;
  logic               sat_q;
  logic               div_start_q;
  logic               div_im_q;
  logic               done_q;
  logic signed [31:0] res_re_q, res_im_q;
  logic        [1:0]  status_q;

  logic signed [31:0] mx, my;
  logic signed [63:0] tr;
  logic signed [64:0] tr65;
  logic signed [64:0] im_fin;
  sat_t               s_re, s_im;
  sat_t               s_add_re, s_add_im, s_sub_re, s_sub_im, s_neg_ai, s_neg_bi;
  logic        [7:0]  exp_n;
  logic               div_done;
  div_res_t           div_res;

  // operand select for the shared multiplier, one real product per step
  always_comb begin
    case (step_q)
      3'd1:    begin mx = xi_q; my = yi_q; end
      3'd2:    begin mx = xr_q; my = yi_q; end
      3'd3:    begin mx = xi_q; my = yr_q; end
      default: begin mx = xr_q; my = yr_q; end
    endcase
  end

  cau_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .x_i   (mx),
    .y_i   (my),
    .tr_o  (tr)
  );

  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_im_q ? ni_q : nr_q),
    .den_i   (d_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    tr65     = 65'(tr);
    im_fin   = acc_im_q + tr65;
    s_re     = sat32(acc_re_q);
    s_im     = sat32(im_fin);
    s_add_re = sat32(65'(a_re_i) + 65'(b_re_i));
    s_add_im = sat32(65'(a_im_i) + 65'(b_im_i));
    s_sub_re = sat32(65'(a_re_i) - 65'(b_re_i));
    s_sub_im = sat32(65'(a_im_i) - 65'(b_im_i));
    s_neg_ai = sat32(-65'(a_im_i));
    s_neg_bi = sat32(-65'(b_im_i));
    // power count clamps to the largest supported exponent
    exp_n    = ({8'd0, exponent_i} > MAX_E) ? MAX_E[7:0] : exponent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            sat_q  <= 1'b0;
            step_q <= 3'd0;
            br_q   <= b_re_i;
            bi_q   <= b_im_i;
            xr_q   <= a_re_i;
            xi_q   <= a_im_i;
            yr_q   <= b_re_i;
            yi_q   <= b_im_i;
            sq_q   <= 1'b0;
            case (kind_i)
              KIND_ADD: begin
                res_re_q <= s_add_re.val;
                res_im_q <= s_add_im.val;
                status_q <= (s_add_re.hit | s_add_im.hit) ? STAT_SAT : STAT_OK;
                done_q   <= 1'b1;
              end
              KIND_SUB: begin
                res_re_q <= s_sub_re.val;
                res_im_q <= s_sub_im.val;
                status_q <= (s_sub_re.hit | s_sub_im.hit) ? STAT_SAT : STAT_OK;
                done_q   <= 1'b1;
              end
              KIND_CONJ: begin
                res_re_q <= a_re_i;
                res_im_q <= s_neg_ai.val;
                status_q <= s_neg_ai.hit ? STAT_SAT : STAT_OK;
                done_q   <= 1'b1;
              end
              KIND_MUL: begin
                phase_q <= PH_MUL;
                state_q <= S_MAC;
              end
              KIND_DIV: begin
                // numerator is a times the conjugate of b
                yi_q    <= s_neg_bi.val;
                sat_q   <= s_neg_bi.hit;
                phase_q <= PH_DIVN;
                state_q <= S_MAC;
              end
              KIND_SQM: begin
                yr_q    <= a_re_i;
                yi_q    <= a_im_i;
                sq_q    <= 1'b1;
                phase_q <= PH_SQM;
                state_q <= S_MAC;
              end
              KIND_POW: begin
                if (exp_n == 8'd0) begin
                  res_re_q <= ONE;
                  res_im_q <= '0;
                  status_q <= STAT_OK;
                  done_q   <= 1'b1;
                end else begin
                  xr_q    <= ONE;
                  xi_q    <= '0;
                  yr_q    <= a_re_i;
                  yi_q    <= a_im_i;
                  cnt_q   <= exp_n;
                  phase_q <= PH_POW;
                  state_q <= S_MAC;
                end
              end
              default: begin
                res_re_q <= '0;
                res_im_q <= '0;
                status_q <= STAT_OK;
                done_q   <= 1'b1;
              end
            endcase
          end
        end

        S_MAC: begin
          step_q <= step_q + 3'd1;
          case (step_q)
            3'd1: acc_re_q <= tr65;
            3'd2: acc_re_q <= sq_q ? (acc_re_q + tr65) : (acc_re_q - tr65);
            3'd3: acc_im_q <= tr65;
            3'd4: begin
              step_q <= 3'd0;
              case (phase_q)
                PH_MUL: begin
                  res_re_q <= s_re.val;
                  res_im_q <= s_im.val;
                  status_q <= (sat_q | s_re.hit | s_im.hit) ? STAT_SAT : STAT_OK;
                  done_q   <= 1'b1;
                  state_q  <= S_IDLE;
                end
                PH_SQM: begin
                  res_re_q <= s_re.val;
                  res_im_q <= '0;
                  status_q <= (sat_q | s_re.hit) ? STAT_SAT : STAT_OK;
                  done_q   <= 1'b1;
                  state_q  <= S_IDLE;
                end
                PH_POW: begin
                  // running product feeds the next pass
                  xr_q  <= s_re.val;
                  xi_q  <= s_im.val;
                  sat_q <= sat_q | s_re.hit | s_im.hit;
                  cnt_q <= cnt_q - 8'd1;
                  if (cnt_q == 8'd1) begin
                    res_re_q <= s_re.val;
                    res_im_q <= s_im.val;
                    status_q <= (sat_q | s_re.hit | s_im.hit) ? STAT_SAT : STAT_OK;
                    done_q   <= 1'b1;
                    state_q  <= S_IDLE;
                  end
                end
                PH_DIVN: begin
                  nr_q    <= s_re.val;
                  ni_q    <= s_im.val;
                  sat_q   <= sat_q | s_re.hit | s_im.hit;
                  xr_q    <= br_q;
                  xi_q    <= bi_q;
                  yr_q    <= br_q;
                  yi_q    <= bi_q;
                  sq_q    <= 1'b1;
                  phase_q <= PH_DIVD;
                end
                PH_DIVD: begin
                  if (s_re.val <= 32'sd0) begin
                    // divisor magnitude truncates to zero
                    res_re_q <= '0;
                    res_im_q <= '0;
                    status_q <= STAT_DIVZ;
                    done_q   <= 1'b1;
                    state_q  <= S_IDLE;
                  end else begin
                    d_q         <= s_re.val;
                    sat_q       <= sat_q | s_re.hit;
                    div_im_q    <= 1'b0;
                    div_start_q <= 1'b1;
                    state_q     <= S_DIV;
                  end
                end
                default: state_q <= S_IDLE;
              endcase
            end
            default: ;
          endcase
        end

        S_DIV: begin
          if (div_done) begin
            if (!div_im_q) begin
              res_re_q    <= div_res.q;
              sat_q       <= sat_q | div_res.sat;
              div_im_q    <= 1'b1;
              div_start_q <= 1'b1;
            end else begin
              res_im_q <= div_res.q;
              status_q <= (sat_q | div_res.sat) ? STAT_SAT : STAT_OK;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign result_re_o = res_re_q;
  assign result_im_o = res_im_q;
  assign status_o    = status_q;

endmodule

// ===== hdl/cau_checker.sv =====
// port-level checks for the complex arithmetic unit, bound to the top level
module cau_checker
  import cau_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic        [2:0]  kind_i,
  input logic               done_o,
  input logic signed [31:0] result_re_o,
  input logic signed [31:0] result_im_o,
  input logic        [1:0]  status_o
);

  // no status code beyond saturated
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_OK || status_o == STAT_DIVZ || status_o == STAT_SAT))
    else $error("status code out of range");

  // divide by zero gives a zero result
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_DIVZ) |-> (result_re_o == 32'sd0 && result_im_o == 32'sd0))
    else $error("divide by zero with nonzero result");

  // simple operations answer in the next cycle without going busy
  a_simple_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_ADD || kind_i == KIND_SUB || kind_i == KIND_CONJ))
    |=> (done_o && !busy))
    else $error("simple transaction not completed in one cycle");

  // a multiply transaction holds busy and has no immediate strobe
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_MUL) |=> (busy && !done_o))
    else $error("multiply transaction not sequenced");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .kind_i      (kind_i),
  .done_o      (done_o),
  .result_re_o (result_re_o),
  .result_im_o (result_im_o),
  .status_o    (status_o)
);
